@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL. Every check is clocked on aclk and
// is disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, off during reset
`define CLBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Implication check: antecedent in one cycle, consequent in the next
`define CLBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/clbc_pkg.sv @@
// ----------------------------------------------------------------------------
// clbc_pkg
// Types, register indexes, mode codes and reset values of the charge limit
// band controller.
// ----------------------------------------------------------------------------
package clbc_pkg;

    // Field widths
    localparam int LEVEL_W   = 7;
    localparam int CURRENT_W = 32;
    localparam int LIMIT_W   = 31;
    localparam int OFFLINE_W = 8;
    localparam int FAKE_CNT_W = 3;
    localparam int HOT_CNT_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LEVEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFLINE_TICKS = 3'd4;

    // Reset values of the configuration registers
    localparam logic [LEVEL_W-1:0]   UPPER_LEVEL_RST   = 7'd80;
    localparam logic [LEVEL_W-1:0]   LOWER_LEVEL_RST   = 7'd75;
    localparam logic [LIMIT_W-1:0]   CURRENT_LIMIT_RST = 31'd150000;
    localparam logic [OFFLINE_W-1:0] OFFLINE_TICKS_RST = 8'd5;

    // Hot sampling starts once the fake tick count passes this value
    localparam logic [FAKE_CNT_W-1:0] HOT_SAMPLE_AFTER = 3'd3;
    // Consecutive hot samples that back the fake off
    localparam logic [HOT_CNT_W-1:0]  HOT_TRIP         = 2'd2;

    // Result modes
    localparam logic [1:0] MODE_RELEASE  = 2'd0;
    localparam logic [1:0] MODE_WIRED    = 2'd1;
    localparam logic [1:0] MODE_WIRELESS = 2'd2;

    typedef struct packed {
        logic [CURRENT_W-1:0] battery_current;
        logic                 wired_up;
        logic                 wireless_up;
        logic                 level_valid;
        logic [LEVEL_W-1:0]   level;
    } clbc_item_t;

    typedef struct packed {
        logic                 enable;
        logic [LEVEL_W-1:0]   upper_level;
        logic [LEVEL_W-1:0]   lower_level;
        logic [LIMIT_W-1:0]   current_limit;
        logic [OFFLINE_W-1:0] offline_ticks;
    } clbc_cfg_t;

    // Packed so that mode lands in the lowest bits of the output tdata
    typedef struct packed {
        logic       backoff;
        logic       holding;
        logic       fake_full;
        logic       restrict_on;
        logic       vote_stop;
        logic       gate_enable;
        logic [1:0] mode;
    } clbc_result_t;

    localparam int RESULT_W = $bits(clbc_result_t);

endpackage

@@ design/clbc_core.sv @@
// ----------------------------------------------------------------------------
// clbc_core
// Per-tick decision logic and the controller state: hysteresis, offline
// counter, fake tick counter, hot sample counter and the unsafe latch.
// ----------------------------------------------------------------------------
module clbc_core
    import clbc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,      // commit this tick's state update
    input  clbc_item_t   item,
    input  clbc_cfg_t    cfg,
    output clbc_result_t result
);

    logic                  hold_reg,      hold_next;
    logic                  prev_hold_reg, prev_hold_next;
    logic [OFFLINE_W-1:0]  offline_reg,   offline_next;
    logic [FAKE_CNT_W-1:0] fake_cnt_reg,  fake_cnt_next;
    logic [HOT_CNT_W-1:0]  hot_cnt_reg,   hot_cnt_next;
    logic                  unsafe_reg,    unsafe_next;

    logic                  engage;
    logic                  gone;
    logic                  active;
    logic                  hot;
    logic [FAKE_CNT_W-1:0] fake_cnt_base;
    logic [HOT_CNT_W-1:0]  hot_cnt_base;
    logic                  unsafe_base;

    // Signed compare of the current against the unsigned limit, one bit wider
    assign hot = $signed({item.battery_current[CURRENT_W-1], item.battery_current})
               > $signed({2'b00, cfg.current_limit});

    // Next state and result for one tick
    always_comb begin
        hold_next      = hold_reg;
        prev_hold_next = prev_hold_reg;
        offline_next   = offline_reg;
        fake_cnt_next  = fake_cnt_reg;
        hot_cnt_next   = hot_cnt_reg;
        unsafe_next    = unsafe_reg;
        engage         = 1'b0;
        gone           = 1'b0;
        active         = 1'b0;
        fake_cnt_base  = fake_cnt_reg;
        hot_cnt_base   = hot_cnt_reg;
        unsafe_base    = unsafe_reg;

        result             = '0;
        result.mode        = MODE_RELEASE;
        result.gate_enable = 1'b1;

        if (!cfg.enable) begin
            hold_next      = 1'b0;
            prev_hold_next = 1'b0;
            offline_next   = '0;
            fake_cnt_next  = '0;
            hot_cnt_next   = '0;
            unsafe_next    = 1'b0;
        end else begin
            // Hysteresis; upper check wins when the band overlaps
            if (item.level_valid) begin
                if (item.level >= cfg.upper_level) begin
                    hold_next = 1'b1;
                end else if (item.level <= cfg.lower_level) begin
                    hold_next = 1'b0;
                end
            end

            // Fresh engagement clears the fake bookkeeping
            engage = hold_next && !prev_hold_reg;
            if (engage) begin
                fake_cnt_base = '0;
                hot_cnt_base  = '0;
                unsafe_base   = 1'b0;
            end
            fake_cnt_next = fake_cnt_base;
            hot_cnt_next  = hot_cnt_base;
            unsafe_next   = unsafe_base;

            // Saturating offline counter
            if (item.wireless_up) begin
                offline_next = '0;
            end else if (offline_reg != '1) begin
                offline_next = offline_reg + 1'b1;
            end
            gone = offline_next >= cfg.offline_ticks;

            if (hold_next) begin
                if (item.wired_up) begin
                    result.mode        = MODE_WIRED;
                    result.gate_enable = 1'b0;
                end else begin
                    active             = !unsafe_base && !gone;
                    result.mode        = MODE_WIRELESS;
                    result.vote_stop   = 1'b1;
                    result.restrict_on = 1'b1;
                    result.fake_full   = active;
                    if (active) begin
                        if (fake_cnt_base != '1) begin
                            fake_cnt_next = fake_cnt_base + 1'b1;
                        end
                        // Sample current once the fake has settled
                        if (fake_cnt_next > HOT_SAMPLE_AFTER) begin
                            if (hot) begin
                                if (hot_cnt_base != '1) begin
                                    hot_cnt_next = hot_cnt_base + 1'b1;
                                end
                            end else begin
                                hot_cnt_next = '0;
                            end
                            if (hot_cnt_next >= HOT_TRIP) begin
                                result.fake_full = 1'b0;
                                result.backoff   = 1'b1;
                                unsafe_next      = 1'b1;
                            end
                        end
                    end
                end
            end
            prev_hold_next = hold_next;
        end

        result.holding = hold_next;
    end

    // State registers, updated once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg      <= 1'b0;
            prev_hold_reg <= 1'b0;
            offline_reg   <= '0;
            fake_cnt_reg  <= '0;
            hot_cnt_reg   <= '0;
            unsafe_reg    <= 1'b0;
        end else if (step) begin
            hold_reg      <= hold_next;
            prev_hold_reg <= prev_hold_next;
            offline_reg   <= offline_next;
            fake_cnt_reg  <= fake_cnt_next;
            hot_cnt_reg   <= hot_cnt_next;
            unsafe_reg    <= unsafe_next;
        end
    end

endmodule

@@ design/charge_limit_band_controller.sv @@
// ----------------------------------------------------------------------------
// charge_limit_band_controller
// Keeps the battery inside a charge band and selects the hold mode per tick.
// ----------------------------------------------------------------------------
// One tick enters per clock cycle while s_tready is high. The tick is captured
// in an input register and decided by a single layer of compare and counter
// logic against the controller state as it moves on to the output register,
// where the result is held until taken. A stalled output holds one result
// while a second tick waits in the input register. Configuration writes are
// always accepted (cfg_ready is tied high) and must only be made while no tick
// is in flight. Register indexes: 0 enable, 1 upper_level, 2 lower_level,
// 3 current_limit, 4 offline_ticks; other indexes are ignored.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module charge_limit_band_controller
    import clbc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Tick input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [6:0] level, [7] wireless_up, [8] wired_up, [40:9] battery_current
    input  logic [47:0]           s_tdata,
    // [0] level_valid
    input  logic                  s_tuser,

    // Result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] mode, [2] gate_enable, [3] vote_stop, [4] restrict_on,
    // [5] fake_full, [6] holding, [7] backoff
    output logic [RESULT_W-1:0]   m_tdata,

    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    clbc_cfg_t    cfg_reg;
    logic         in_valid_reg;
    clbc_item_t   item_reg;
    logic         out_valid_reg;
    clbc_result_t result_reg;
    clbc_result_t result;
    logic         advance;
    logic         s_accept;

    // Input register moves forward when the output register is free or drains
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = result_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable        <= 1'b0;
            cfg_reg.upper_level   <= UPPER_LEVEL_RST;
            cfg_reg.lower_level   <= LOWER_LEVEL_RST;
            cfg_reg.current_limit <= CURRENT_LIMIT_RST;
            cfg_reg.offline_ticks <= OFFLINE_TICKS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ENABLE:        cfg_reg.enable        <= cfg_wdata[0];
                REG_UPPER_LEVEL:   cfg_reg.upper_level   <= cfg_wdata[LEVEL_W-1:0];
                REG_LOWER_LEVEL:   cfg_reg.lower_level   <= cfg_wdata[LEVEL_W-1:0];
                REG_CURRENT_LIMIT: cfg_reg.current_limit <= cfg_wdata[LIMIT_W-1:0];
                REG_OFFLINE_TICKS: cfg_reg.offline_ticks <= cfg_wdata[OFFLINE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.level           <= s_tdata[6:0];
            item_reg.wireless_up     <= s_tdata[7];
            item_reg.wired_up        <= s_tdata[8];
            item_reg.battery_current <= s_tdata[40:9];
            item_reg.level_valid     <= s_tuser;
        end
    end

    clbc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    // A tick decided while disabled gives the released result
    `CLBC_ASSERT_NEXT(a_disabled_release, advance && !cfg_reg.enable, (result_reg.mode == MODE_RELEASE) && result_reg.gate_enable && !result_reg.holding && !result_reg.backoff, "disabled tick did not release")
    // Backoff only happens in wireless hold and drops the fake
    `CLBC_ASSERT(a_backoff_wireless, !(m_tvalid && result_reg.backoff) || ((result_reg.mode == MODE_WIRELESS) && !result_reg.fake_full && result_reg.holding), "backoff outside wireless hold")
    // Input stalls only with both registers full and the output blocked
    `CLBC_ASSERT(a_stall_cause, s_tready || (in_valid_reg && out_valid_reg && !m_tready), "input stalled without cause")

endmodule
